@@ rtl/pfcib_pkg.sv @@
package pfcib_pkg;

    // Width of every byte counter and of the wide configuration registers.
    localparam int CNT_W   = 28;
    localparam int SIZE_W  = 16;
    localparam int PORT_W  = 5;
    localparam int QUEUE_W = 3;
    localparam int IDX_W   = 3;

    localparam logic [CNT_W-1:0] CNT_MAX    = {CNT_W{1'b1}};
    localparam logic [CNT_W-1:0] POOL_RESET = CNT_W'(12 * 1024 * 1024);

    // Configuration register indexes.
    localparam logic [IDX_W-1:0] REG_POOL      = 3'd0;
    localparam logic [IDX_W-1:0] REG_DYN_EN    = 3'd1;
    localparam logic [IDX_W-1:0] REG_DYN_SHIFT = 3'd2;
    localparam logic [IDX_W-1:0] REG_HEADROOM  = 3'd3;
    localparam logic [IDX_W-1:0] REG_RESERVE   = 3'd4;
    localparam logic [IDX_W-1:0] REG_RESUME    = 3'd5;

    // Where an event's bytes were charged.
    typedef enum logic [1:0] {
        CHG_RESERVE  = 2'd0,
        CHG_SHARED   = 2'd1,
        CHG_HEADROOM = 2'd2,
        CHG_NONE     = 2'd3
    } charge_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOAD,
        ST_DECIDE,
        ST_SHARE,
        ST_TOTAL,
        ST_THR,
        ST_FLAG
    } state_t;

    // One per-queue entry of the accounting memory.
    typedef struct packed {
        logic [CNT_W-1:0] ingress_used;
        logic [CNT_W-1:0] headroom_used;
        logic             paused;
    } entry_t;

    // Clamp a sum that may have grown by one bit to the counter range.
    function automatic logic [CNT_W-1:0] sat28(input logic [CNT_W:0] v);
        logic [CNT_W-1:0] r;
        r = v[CNT_W] ? CNT_MAX : v[CNT_W-1:0];
        return r;
    endfunction

endpackage

@@ rtl/pfc_ingress_buffer_admission.sv @@
// An in-range event passes in turn through the load, decide, share, total, threshold and
// flag states before its result is registered; an event naming a port or queue out of range
// goes from idle straight to the flag state. The flag state holds while the result register
// is full and not taken. One event is handled at a time, around the single accounting memory.
// Reset: asynchronous, active low. After reset a clearing pass zeroes each of the
// PORTS*QUEUES_PER_PORT memory entries; no input transfer is taken until it has finished.
module pfc_ingress_buffer_admission #(
    parameter int PORTS           = 32,
    parameter int QUEUES_PER_PORT = 8
) (
    input  logic                       clk,
    input  logic                       rst_n,
    // Input stream.
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [23:0]                s_tdata,    // port[4:0], queue[7:5], packet_bytes[23:8]
    input  logic                       s_tuser,    // mode: 0 arrival, 1 departure
    // Result stream.
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [7:0]                 m_tdata,    // admitted[0], charged_to[2:1],
                                                   // send_pause[3], send_resume[4], zero[7:5]
    // Configuration writes.
    input  logic                       cfg_we,
    input  logic [pfcib_pkg::IDX_W-1:0] cfg_index,
    input  logic [pfcib_pkg::CNT_W-1:0] cfg_wdata
);
    import pfcib_pkg::*;

    localparam int SLOTS  = PORTS * QUEUES_PER_PORT;
    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    // ------------------------------------------------------------------
    // Configuration registers.
    // ------------------------------------------------------------------
    logic [CNT_W-1:0] pool_reg;
    logic             dyn_en_reg;
    logic [3:0]       dyn_shift_reg;
    logic [CNT_W-1:0] headroom_size_reg;
    logic [CNT_W-1:0] reserve_reg;
    logic [CNT_W-1:0] resume_off_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pool_reg          <= POOL_RESET;
            dyn_en_reg        <= 1'b0;
            dyn_shift_reg     <= 4'd0;
            headroom_size_reg <= '0;
            reserve_reg       <= '0;
            resume_off_reg    <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_POOL:      pool_reg          <= cfg_wdata;
                REG_DYN_EN:    dyn_en_reg        <= cfg_wdata[0];
                REG_DYN_SHIFT: dyn_shift_reg     <= cfg_wdata[3:0];
                REG_HEADROOM:  headroom_size_reg <= cfg_wdata;
                REG_RESERVE:   reserve_reg       <= cfg_wdata;
                REG_RESUME:    resume_off_reg    <= cfg_wdata;
                default:       ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Input field decode. The slot of a queue is port * QUEUES_PER_PORT + queue.
    // ------------------------------------------------------------------
    logic [PORT_W-1:0]  in_port;
    logic [QUEUE_W-1:0] in_queue;
    logic [SIZE_W-1:0]  in_bytes;
    logic               in_range;
    logic [SLOT_W-1:0]  in_slot;

    assign in_port  = s_tdata[4:0];
    assign in_queue = s_tdata[7:5];
    assign in_bytes = s_tdata[23:8];
    assign in_range = (32'(in_port) < PORTS) && (32'(in_queue) < QUEUES_PER_PORT);
    assign in_slot  = SLOT_W'(32'(in_port) * QUEUES_PER_PORT + 32'(in_queue));

    // ------------------------------------------------------------------
    // Sequencer.
    // ------------------------------------------------------------------
    state_t state_reg, state_next;
    logic   out_free;
    logic   accept;
    logic   finish;
    logic [SLOT_W-1:0] clr_cnt_reg;

    assign out_free = !m_tvalid || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign finish   = (state_reg == ST_FLAG) && out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_cnt_reg == SLOT_W'(SLOTS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    state_next = in_range ? ST_LOAD : ST_FLAG;
                end
            end
            ST_LOAD:   state_next = ST_DECIDE;
            ST_DECIDE: state_next = ST_SHARE;
            ST_SHARE:  state_next = ST_TOTAL;
            ST_TOTAL:  state_next = ST_THR;
            ST_THR:    state_next = ST_FLAG;
            ST_FLAG:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // The clearing pass walks the memory once after reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else if (state_reg == ST_CLEAR)
        begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Per-queue accounting memory: one read port, one write port, registered read.
    // Only one event is in flight, so a read never overlaps a pending write
    // to the same entry.
    // ------------------------------------------------------------------
    entry_t            mem [SLOTS];
    entry_t            rd_data_reg;
    logic              mem_we;
    logic [SLOT_W-1:0] mem_waddr;
    entry_t            mem_wdata;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rd_data_reg <= mem[in_slot];
        end
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
    end

    // ------------------------------------------------------------------
    // Event context, latched at the input transfer.
    // ------------------------------------------------------------------
    logic              mode_reg;
    logic              oor_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic [SIZE_W-1:0] bytes_reg;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg  <= s_tuser;
            oor_reg   <= !in_range;
            slot_reg  <= in_slot;
            bytes_reg <= in_bytes;
        end
    end

    // Running shared total; only the touched queue's change is applied.
    logic [CNT_W-1:0] total_reg;

    // Load step: operands from the entry that was read, plus the old threshold from the shared total.
    logic [CNT_W-1:0]  ing_reg;
    logic [CNT_W-1:0]  hr_reg;
    logic              paused_reg;
    logic [CNT_W-1:0]  sq_old_reg;
    logic [CNT_W-1:0]  thr_old_reg;
    logic [CNT_W:0]    new_ing_reg;
    logic [CNT_W:0]    hr_sum_reg;
    logic              over_head_reg;
    logic [CNT_W-1:0]  dep_hr_reg;
    logic [SIZE_W-1:0] dep_rest_reg;

    logic [CNT_W:0]    new_ing_next;
    logic [CNT_W:0]    hr_sum_next;
    logic [CNT_W-1:0]  remain_old;

    assign new_ing_next = {1'b0, rd_data_reg.ingress_used} + (CNT_W + 1)'(bytes_reg);
    assign hr_sum_next  = {1'b0, rd_data_reg.headroom_used} + (CNT_W + 1)'(bytes_reg);
    assign remain_old   = (pool_reg >= total_reg) ? (pool_reg - total_reg) : '0;

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_LOAD)
        begin
            ing_reg       <= rd_data_reg.ingress_used;
            hr_reg        <= rd_data_reg.headroom_used;
            paused_reg    <= rd_data_reg.paused;
            sq_old_reg    <= (rd_data_reg.ingress_used > reserve_reg)
                             ? (rd_data_reg.ingress_used - reserve_reg) : '0;
            thr_old_reg   <= remain_old >> dyn_shift_reg;
            new_ing_reg   <= new_ing_next;
            hr_sum_reg    <= hr_sum_next;
            over_head_reg <= hr_sum_next > {1'b0, headroom_size_reg};
            // A departure drains headroom first; whatever is left comes off ingress.
            if (rd_data_reg.headroom_used < CNT_W'(bytes_reg))
            begin
                dep_hr_reg   <= '0;
                dep_rest_reg <= bytes_reg - rd_data_reg.headroom_used[SIZE_W-1:0];
            end
            else
            begin
                dep_hr_reg   <= rd_data_reg.headroom_used - CNT_W'(bytes_reg);
                dep_rest_reg <= '0;
            end
        end
    end

    // Decide step: admission test and where the bytes are charged.
    logic             admitted_reg;
    charge_t          charge_reg;
    logic             ing_wr_reg;
    logic [CNT_W-1:0] ing_new_reg;
    logic [CNT_W-1:0] hr_new_reg;

    logic           over_shared;
    logic [CNT_W:0] lim;
    logic [CNT_W:0] over_reserve;

    always_comb
    begin
        if (dyn_en_reg)
        begin
            over_shared = ({1'b0, sq_old_reg} + (CNT_W + 1)'(bytes_reg)) > {1'b0, thr_old_reg};
            lim         = {1'b0, thr_old_reg};
        end
        else
        begin
            over_shared = ({1'b0, total_reg} + (CNT_W + 1)'(bytes_reg)) > {1'b0, pool_reg};
            lim         = {1'b0, pool_reg};
        end
        over_reserve = new_ing_reg - {1'b0, reserve_reg};
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_DECIDE)
        begin
            ing_new_reg <= ing_reg;
            hr_new_reg  <= hr_reg;
            ing_wr_reg  <= 1'b0;
            if (mode_reg)
            begin
                admitted_reg <= 1'b1;
                charge_reg   <= CHG_NONE;
                hr_new_reg   <= dep_hr_reg;
                ing_wr_reg   <= 1'b1;
                ing_new_reg  <= (ing_reg > CNT_W'(dep_rest_reg))
                                ? (ing_reg - CNT_W'(dep_rest_reg)) : '0;
            end
            else if (over_shared && over_head_reg)
            begin
                admitted_reg <= 1'b0;
                charge_reg   <= CHG_NONE;
            end
            else if (new_ing_reg <= {1'b0, reserve_reg})
            begin
                admitted_reg <= 1'b1;
                charge_reg   <= CHG_RESERVE;
                ing_wr_reg   <= 1'b1;
                ing_new_reg  <= sat28(new_ing_reg);
            end
            else if (over_reserve > lim)
            begin
                admitted_reg <= 1'b1;
                charge_reg   <= CHG_HEADROOM;
                hr_new_reg   <= sat28(hr_sum_reg);
            end
            else
            begin
                admitted_reg <= 1'b1;
                charge_reg   <= CHG_SHARED;
                ing_wr_reg   <= 1'b1;
                ing_new_reg  <= sat28(new_ing_reg);
            end
        end
    end

    // Share step: new shared use of the queue and the total with the old use removed.
    logic [CNT_W-1:0] sq_new_reg;
    logic [CNT_W-1:0] total_less_reg;

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_SHARE)
        begin
            sq_new_reg     <= (ing_new_reg > reserve_reg) ? (ing_new_reg - reserve_reg) : '0;
            total_less_reg <= (total_reg >= sq_old_reg) ? (total_reg - sq_old_reg) : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg <= '0;
        end
        else if ((state_reg == ST_TOTAL) && ing_wr_reg)
        begin
            total_reg <= sat28({1'b0, total_less_reg} + {1'b0, sq_new_reg});
        end
    end

    // Threshold step: dynamic threshold from the updated total.
    logic [CNT_W-1:0] thr_new_reg;
    logic [CNT_W-1:0] remain_new;

    assign remain_new = (pool_reg >= total_reg) ? (pool_reg - total_reg) : '0;

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_THR)
        begin
            thr_new_reg <= remain_new >> dyn_shift_reg;
        end
    end

    // Flag step: pause and resume evaluation, write-back and result.
    logic pause_cond;
    logic resume_ok;
    logic send_pause;
    logic send_resume;
    logic paused_new;

    always_comb
    begin
        pause_cond = (hr_new_reg != '0) || (dyn_en_reg && (sq_new_reg >= thr_new_reg));
        if (sq_new_reg == '0)
        begin
            resume_ok = 1'b1;
        end
        else if (dyn_en_reg)
        begin
            resume_ok = ({1'b0, sq_new_reg} + {1'b0, resume_off_reg}) <= {1'b0, thr_new_reg};
        end
        else
        begin
            resume_ok = ({1'b0, total_reg} + {1'b0, resume_off_reg}) <= {1'b0, pool_reg};
        end
        send_pause  = !paused_reg && pause_cond;
        send_resume = paused_reg && (hr_new_reg == '0) && resume_ok;
        paused_new  = (paused_reg || send_pause) && !send_resume;
    end

    always_comb
    begin
        if (state_reg == ST_CLEAR)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_cnt_reg;
            mem_wdata = '0;
        end
        else
        begin
            mem_we    = finish && !oor_reg;
            mem_waddr = slot_reg;
            mem_wdata = '{ingress_used: ing_new_reg, headroom_used: hr_new_reg,
                          paused: paused_new};
        end
    end

    // Output register: the next event may enter while a result waits here.
    logic [7:0] m_tdata_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid <= 1'b0;
        end
        else if (finish)
        begin
            m_tvalid <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (finish)
        begin
            if (oor_reg)
            begin
                // A port or queue out of range writes neither the memory nor the shared total.
                m_tdata_reg <= {3'b000, 1'b0, 1'b0, CHG_NONE, mode_reg};
            end
            else
            begin
                m_tdata_reg <= {3'b000, send_resume, send_pause, charge_reg, admitted_reg};
            end
        end
    end

    assign m_tdata = m_tdata_reg;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    a_accept_next: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ST_LOAD) || (state_reg == ST_FLAG))
        else $error("event did not proceed to load or result after its transfer");

    a_drop_code: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tdata[0]) |-> (m_tdata[2:1] == CHG_NONE))
        else $error("refused arrival carries a charge code");

    a_pause_resume: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tdata[3] && m_tdata[4]))
        else $error("pause and resume requested together");

    a_total_only_on_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_TOTAL) |=> $stable(total_reg))
        else $error("shared total changed outside its update step");

endmodule
